// File: hdl/vmp_pkg.sv
// vmp_pkg: shared types, constants and command struct for the vertex projector
// no dependencies
`timescale 1ns / 1ps
package vmp_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam logic [1:0] MAT_MODEL = 2'd0;
   localparam logic [1:0] MAT_VIEW  = 2'd1;
   localparam logic [1:0] MAT_PROJ  = 2'd2;
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_XFORM = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic       load_vec;   // latch vertex into vector regs
      logic       wr_elem;    // write matrix element
      logic       mac;        // one multiply-accumulate step
      logic       mac_first;  // clear accumulator
      logic       col_done;   // saturate accumulator into next-vector slot
      logic [1:0] mat;        // matrix in use
      logic [1:0] row;
      logic [1:0] col;
      logic       swap;       // next-vector becomes current vector
      logic       div_start;  // start divide of component col
      logic       out_load;   // copy quotients to output regs
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } sts_type;
endpackage

// File: hdl/vmp_divider.sv
// vmp_divider: radix-2 restoring divider, one quotient bit a cycle, saturating
// depends on vmp_pkg
`timescale 1ns / 1ps
module vmp_divider #(
   parameter int FRAC_BITS = vmp_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               busy,
   output logic signed [31:0] quot
);
   localparam int NW = 32 + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [32:0]   r_ff, r_in;
   logic [31:0]   d_ff, d_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [33:0]   trial;
   logic [31:0]   nm, dm;

   assign nm = num[31] ? 32'(-num) : 32'(num);
   assign dm = den[31] ? 32'(-den) : 32'(den);
   assign trial = {r_ff, q_ff[NW-1]} - {2'b00, d_ff};

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      if (start) begin
         q_in = {nm, FRAC_BITS'(0)};
         r_in = '0; d_in = dm;
         neg_in = num[31] ^ den[31];
         cnt_in = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[33]) begin
            r_in = trial[32:0];
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[31:0], q_ff[NW-1]};
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in;
   end

   assign busy = busy_ff;
   always_comb begin
      if (neg_ff) begin
         if (q_ff > NW'(33'h80000000)) quot = 32'sh80000000;
         else quot = 32'(-q_ff);
      end else begin
         if (q_ff > NW'(32'h7FFFFFFF)) quot = 32'sh7FFFFFFF;
         else quot = 32'(q_ff);
      end
   end
endmodule

// File: hdl/vmp_datapath.sv
// vmp_datapath: matrix stores, shared multiplier and accumulator, divider
// depends on vmp_pkg and vmp_divider
`timescale 1ns / 1ps
module vmp_datapath #(
   parameter int FRAC_BITS = vmp_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  vmp_pkg::cmd_type   cmd,
   output vmp_pkg::sts_type   sts,
   input  logic [3:0]         elem_index,
   input  logic signed [31:0] elem_value,
   input  logic signed [31:0] vx,
   input  logic signed [31:0] vy,
   input  logic signed [31:0] vz,
   output logic signed [31:0] px,
   output logic signed [31:0] py,
   output logic signed [31:0] pz,
   output logic               div_zero
);
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   logic signed [31:0] model_ff [16];
   logic signed [31:0] view_ff [16];
   logic signed [31:0] proj_ff [16];
   logic signed [31:0] v_ff [4];
   logic signed [31:0] n_ff [4];
   logic signed [63:0] prod_ff;
   logic               prod_v_ff;
   logic               pfirst_ff;
   logic signed [63:0] acc_ff;
   logic signed [31:0] q_ff [3];
   logic signed [31:0] out_ff [3];
   logic               dz_ff;
   logic signed [31:0] msel;
   logic signed [63:0] pshift;
   logic signed [63:0] acc_in;
   logic signed [31:0] sat;
   logic               dbusy;
   logic signed [31:0] dquot;
   logic [1:0]         dcol_ff;
   logic               dpend_ff;

   always_comb begin
      case (cmd.mat)
         vmp_pkg::MAT_MODEL: msel = model_ff[{cmd.row, cmd.col}];
         vmp_pkg::MAT_VIEW:  msel = view_ff[{cmd.row, cmd.col}];
         vmp_pkg::MAT_PROJ:  msel = proj_ff[{cmd.row, cmd.col}];
         default:            msel = 32'sd0;
      endcase
   end

   assign pshift = prod_ff >>> FRAC_BITS;
   // four shifted products summed exactly, saturated only at column end
   assign acc_in = (pfirst_ff ? 64'sd0 : acc_ff) + pshift;
   assign sat = (acc_ff > 64'sd2147483647) ? 32'sh7FFFFFFF :
                (acc_ff < -64'sd2147483648) ? 32'sh80000000 : 32'(acc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 16; k++) begin
            model_ff[k] <= (k % 5 == 0) ? ONE : 32'sd0;
            view_ff[k] <= (k % 5 == 0) ? ONE : 32'sd0;
            proj_ff[k] <= (k % 5 == 0) ? ONE : 32'sd0;
         end
         prod_v_ff <= 1'b0;
         dpend_ff <= 1'b0;
      end else begin
         if (cmd.wr_elem) begin
            case (cmd.mat)
               vmp_pkg::MAT_MODEL: model_ff[elem_index] <= elem_value;
               vmp_pkg::MAT_VIEW:  view_ff[elem_index] <= elem_value;
               vmp_pkg::MAT_PROJ:  proj_ff[elem_index] <= elem_value;
               default: ;
            endcase
         end
         prod_v_ff <= cmd.mac;
         dpend_ff <= cmd.div_start || (dpend_ff && dbusy);
      end
      if (cmd.load_vec) begin
         v_ff[0] <= vx; v_ff[1] <= vy; v_ff[2] <= vz; v_ff[3] <= ONE;
      end
      prod_ff <= v_ff[cmd.row] * msel;
      pfirst_ff <= cmd.mac_first;
      if (prod_v_ff) acc_ff <= acc_in;
      if (cmd.col_done) n_ff[cmd.col] <= sat;
      // swap comes with the last column, whose sum is still in sat
      if (cmd.swap) v_ff <= '{n_ff[0], n_ff[1], n_ff[2], sat};
      if (cmd.div_start) dcol_ff <= cmd.col;
      if (dpend_ff && !dbusy && dcol_ff != 2'd3) q_ff[dcol_ff] <= dquot;
      if (cmd.out_load) begin
         dz_ff <= (v_ff[3] == 32'sd0);
         for (int k = 0; k < 3; k++)
            out_ff[k] <= (v_ff[3] == 32'sd0) ?
               (v_ff[k][31] ? 32'sh80000000 : 32'sh7FFFFFFF) : q_ff[k];
      end
   end

   vmp_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .num(v_ff[cmd.col]), .den(v_ff[3]), .busy(dbusy), .quot(dquot));

   assign sts.div_busy = dbusy || cmd.div_start;
   assign px = out_ff[0];
   assign py = out_ff[1];
   assign pz = out_ff[2];
   assign div_zero = dz_ff;
endmodule

// File: hdl/vmp_control.sv
// vmp_control: sequencer for loads, three vector-matrix passes and the divides
// depends on vmp_pkg
`timescale 1ns / 1ps
module vmp_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_op,
   input  logic [1:0]       req_mat_sel,
   input  logic             req_last_in,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_last_out,
   output vmp_pkg::cmd_type cmd,
   input  vmp_pkg::sts_type sts
);
   typedef enum logic [2:0] {S_IDLE, S_MAC, S_DRAIN, S_SAT, S_DIV, S_DWAIT, S_OUT}
      state_type;

   state_type  state_ff, state_in;
   logic [1:0] mat_ff, mat_in, row_ff, row_in, col_ff, col_in;
   logic [1:0] drain_ff, drain_in;
   logic       vld_ff, vld_in, last_ff, last_in;

   always_comb begin
      state_in = state_ff; mat_in = mat_ff; row_in = row_ff; col_in = col_ff;
      drain_in = drain_ff; vld_in = vld_ff; last_in = last_ff;
      cmd = '0;
      cmd.mat = mat_ff; cmd.row = row_ff; cmd.col = col_ff;
      if (rsp_valid && rsp_ready) vld_in = 1'b0;
      req_ready = (state_ff == S_IDLE) && !vld_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.mat = req_mat_sel;
            if (req_valid && req_ready) begin
               if (req_op == vmp_pkg::OP_LOAD) cmd.wr_elem = 1'b1;
               else begin
                  cmd.load_vec = 1'b1;
                  last_in = req_last_in;
                  mat_in = vmp_pkg::MAT_MODEL; row_in = '0; col_in = '0;
                  state_in = S_MAC;
               end
            end
         end
         S_MAC: begin
            // product registered now, accumulated next cycle
            cmd.mac = 1'b1;
            cmd.mac_first = (row_ff == 2'd0);
            row_in = row_ff + 1'b1;
            if (row_ff == 2'd3) begin
               drain_in = 2'd2;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            drain_in = drain_ff - 1'b1;
            if (drain_ff == 2'd1) state_in = S_SAT;
         end
         S_SAT: begin
            cmd.col_done = 1'b1;
            col_in = col_ff + 1'b1;
            state_in = S_MAC;
            if (col_ff == 2'd3) begin
               cmd.swap = 1'b1;
               if (mat_ff == vmp_pkg::MAT_PROJ) begin
                  col_in = '0;
                  state_in = S_DIV;
               end else mat_in = mat_ff + 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (!sts.div_busy) begin
               col_in = col_ff + 1'b1;
               state_in = (col_ff == 2'd2) ? S_OUT : S_DIV;
            end
         end
         S_OUT: begin
            cmd.out_load = 1'b1;
            vld_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff <= 1'b0;
         mat_ff <= '0; row_ff <= '0; col_ff <= '0; drain_ff <= '0;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in; vld_ff <= vld_in;
         mat_ff <= mat_in; row_ff <= row_in; col_ff <= col_in;
         drain_ff <= drain_in; last_ff <= last_in;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_last_out = last_ff;

`ifndef ASSERT_OFF
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_ready) else $error("ready while busy");
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_out_sets_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |=> rsp_valid) else $error("result not raised");
`endif
endmodule

// File: hdl/vertex_mvp_projector_top.sv
// vertex_mvp_projector_top: mvp vertex transform with perspective divide
// depends on vmp_pkg, vmp_control, vmp_datapath
//
// channel | ports                                   | dir
// req     | req_valid/ready, op, mat_sel, elem_*, v* | in
// rsp     | rsp_valid/ready, px, py, pz, div_zero... | out
//
// load beat: one matrix element write. vertex beat: 3 passes x 4 columns of the
// shared multiplier, plus 3 divides, one per output component.
// one item at a time; a new beat is taken once the result has left.
// reset sets all three matrices to identity.
`timescale 1ns / 1ps
module vertex_mvp_projector_top #(
   parameter int FRAC_BITS = vmp_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [1:0]         req_mat_sel,
   input  logic [3:0]         req_elem_index,
   input  logic signed [31:0] req_elem_value,
   input  logic signed [31:0] req_vx,
   input  logic signed [31:0] req_vy,
   input  logic signed [31:0] req_vz,
   input  logic               req_last_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_px,
   output logic signed [31:0] rsp_py,
   output logic signed [31:0] rsp_pz,
   output logic               rsp_div_zero,
   output logic               rsp_last_out
);
   vmp_pkg::cmd_type cmd;
   vmp_pkg::sts_type sts;

   vmp_control u_ctl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_op(req_op), .req_mat_sel(req_mat_sel), .req_last_in(req_last_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_last_out(rsp_last_out),
      .cmd(cmd), .sts(sts));

   vmp_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .elem_index(req_elem_index), .elem_value(req_elem_value),
      .vx(req_vx), .vy(req_vy), .vz(req_vz),
      .px(rsp_px), .py(rsp_py), .pz(rsp_pz), .div_zero(rsp_div_zero));
endmodule

// File: test/projection_checker.sv
// projection_checker: watches the req and rsp channels of the vertex projector,
// predicts each projected vertex and compares it with what leaves the block
// depends on vmp_pkg for the op and matrix codes and the fraction width
`timescale 1ns / 1ps
module projection_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_op,
   input  logic [1:0]         req_mat_sel,
   input  logic [3:0]         req_elem_index,
   input  logic signed [31:0] req_elem_value,
   input  logic signed [31:0] req_vx,
   input  logic signed [31:0] req_vy,
   input  logic signed [31:0] req_vz,
   input  logic               req_last_in,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_px,
   input  logic signed [31:0] rsp_py,
   input  logic signed [31:0] rsp_pz,
   input  logic               rsp_div_zero,
   input  logic               rsp_last_out,
   output int                 fail_count,
   output int                 pending,
   output int                 vertex_count,
   output int                 zero_w_count
);
   localparam int FB = vmp_pkg::FRAC_BITS_DEF;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;

   typedef struct {
      logic [31:0] px, py, pz;
      logic        div_zero, last_out;
   } projected_type;

   logic signed [31:0] mats [3][16];
   projected_type      projected_q [$];

   function automatic longint clamp32(longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
   endfunction

   function automatic logic [31:0] fixed_ratio(longint n, longint d);
      longint nm, dm, q;
      logic neg;
      nm = (n < 0) ? -n : n;
      dm = (d < 0) ? -d : d;
      neg = (n < 0) != (d < 0);
      q = (nm <<< FB) / dm;
      if (neg) return (q > 64'sh80000000) ? 32'h80000000 : 32'(-q);
      return (q > S32_MAX) ? 32'h7FFFFFFF : 32'(q);
   endfunction

   function automatic projected_type project_vertex(logic signed [31:0] x, y, z,
                                                    logic last);
      longint cur [4];
      longint nxt [4];
      longint acc;
      projected_type p;
      cur[0] = x; cur[1] = y; cur[2] = z; cur[3] = longint'(1) <<< FB;
      for (int m = 0; m < 3; m++) begin
         for (int c = 0; c < 4; c++) begin
            acc = 0;
            // arithmetic shift of the exact product rounds toward minus infinity
            for (int r = 0; r < 4; r++)
               acc += (cur[r] * longint'(mats[m][r*4+c])) >>> FB;
            nxt[c] = clamp32(acc);
         end
         cur = nxt;
      end
      if (cur[3] == 0) begin
         p.px = (cur[0] < 0) ? 32'h80000000 : 32'h7FFFFFFF;
         p.py = (cur[1] < 0) ? 32'h80000000 : 32'h7FFFFFFF;
         p.pz = (cur[2] < 0) ? 32'h80000000 : 32'h7FFFFFFF;
         p.div_zero = 1'b1;
      end else begin
         p.px = fixed_ratio(cur[0], cur[3]);
         p.py = fixed_ratio(cur[1], cur[3]);
         p.pz = fixed_ratio(cur[2], cur[3]);
         p.div_zero = 1'b0;
      end
      p.last_out = last;
      return p;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      projected_type want;
      if (reset) begin
         for (int m = 0; m < 3; m++)
            for (int k = 0; k < 16; k++)
               mats[m][k] = (k % 5 == 0) ? (32'sd1 <<< FB) : 32'sd0;
         projected_q.delete();
         fail_count = 0;
         vertex_count = 0;
         zero_w_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (projected_q.size() == 0) begin
               $error("result beat with nothing expected: px %h", rsp_px);
               fail_count++;
            end else begin
               want = projected_q.pop_front();
               check_field("px", want.px, rsp_px);
               check_field("py", want.py, rsp_py);
               check_field("pz", want.pz, rsp_pz);
               check_field("div_zero", want.div_zero, rsp_div_zero);
               check_field("last_out", want.last_out, rsp_last_out);
            end
         end
         if (req_valid && req_ready) begin
            if (req_op == vmp_pkg::OP_LOAD) begin
               // selector three leaves every matrix alone
               if (req_mat_sel <= vmp_pkg::MAT_PROJ)
                  mats[req_mat_sel][req_elem_index] = req_elem_value;
            end else begin
               want = project_vertex(req_vx, req_vy, req_vz, req_last_in);
               vertex_count++;
               if (want.div_zero) zero_w_count++;
               projected_q.push_back(want);
            end
         end
      end
      pending = projected_q.size();
   end
endmodule

// File: test/testbench.sv
// testbench: drives loads and vertices into the vertex projector under several
// idle and stall mixes; depends on vmp_pkg, vertex_mvp_projector_top, projection_checker
`timescale 1ns / 1ps
module testbench;
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_op = vmp_pkg::OP_LOAD;
   logic [1:0]         req_mat_sel = vmp_pkg::MAT_MODEL;
   logic [3:0]         req_elem_index = '0;
   logic signed [31:0] req_elem_value = '0;
   logic signed [31:0] req_vx = '0;
   logic signed [31:0] req_vy = '0;
   logic signed [31:0] req_vz = '0;
   logic               req_last_in = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_px, rsp_py, rsp_pz;
   logic               rsp_div_zero, rsp_last_out;

   int fail_count, pending, vertex_count, zero_w_count;
   int idle_pct = 0;
   int stall_pct = 0;
   logic hold_rsp = 1'b0;

   vertex_mvp_projector_top dut (.*);

   projection_checker checker_i (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_rsp && ($urandom_range(0, 99) >= stall_pct);
   end

   initial begin
      #60000000;
      $display("simulation failed");
      $finish;
   end

   // one beat: present it, hold until taken, then maybe leave a gap
   task automatic send_beat(logic op, logic [1:0] sel, logic [3:0] idx, logic [31:0] val,
                            logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
      req_valid <= 1'b1;
      req_op <= op;
      req_mat_sel <= sel;
      req_elem_index <= idx;
      req_elem_value <= val;
      req_vx <= x;
      req_vy <= y;
      req_vz <= z;
      req_last_in <= last;
      do @(posedge clock); while (!req_ready);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic load_elem(logic [1:0] sel, logic [3:0] idx, logic [31:0] val);
      send_beat(vmp_pkg::OP_LOAD, sel, idx, val, $urandom, $urandom, $urandom,
                1'($urandom_range(0, 1)));
   endtask

   task automatic vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
      send_beat(vmp_pkg::OP_XFORM, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                $urandom, x, y, z, last);
   endtask

   function automatic logic [31:0] rand_elem();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 32'd0;
      if (r < 75) return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      return $urandom;
   endfunction

   function automatic logic [31:0] rand_coord();
      if ($urandom_range(0, 99) < 75) return $urandom_range(0, 32'h1FFFFFF) - 32'h1000000;
      return $urandom;
   endfunction

   // sender goes quiet until every expected result is out
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic random_run(int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 35)
            load_elem(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), rand_elem());
         else
            vertex(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity matrices pass the extremes straight through
      vertex(32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b0);
      vertex(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1'b1);
      vertex(32'h0, 32'h0, 32'h0, 1'b0);
      // selector three must not touch anything
      load_elem(2'd3, 4'd0, 32'h0);
      load_elem(2'd3, 4'd15, 32'hFFFFFFFF);
      vertex(32'h00010000, 32'h00020000, 32'h00030000, 1'b1);
      // extreme element values into model
      load_elem(vmp_pkg::MAT_MODEL, 4'd0, 32'h7FFFFFFF);
      load_elem(vmp_pkg::MAT_MODEL, 4'd5, 32'h80000000);
      vertex(32'h7FFFFFFF, 32'h80000000, 32'h00010000, 1'b0);
      // tiny w forces divide overflow
      load_elem(vmp_pkg::MAT_PROJ, 4'd15, 32'h00000001);
      vertex(32'h00010000, 32'hFFFF0000, 32'h0, 1'b0);
      // zero w: whole projection column three cleared
      load_elem(vmp_pkg::MAT_PROJ, 4'd15, 32'h0);
      vertex(32'h00010000, 32'hFFFF0000, 32'h0, 1'b1);
      vertex(32'h0, 32'h0, 32'h0, 1'b0);
      load_elem(vmp_pkg::MAT_VIEW, 4'd10, 32'hFFFF0000);
      load_elem(vmp_pkg::MAT_PROJ, 4'd15, 32'h00010000);
      load_elem(vmp_pkg::MAT_PROJ, 4'd11, 32'h00008000);
      vertex(32'h00040000, 32'h00050000, 32'h00020000, 1'b1);
      load_elem(vmp_pkg::MAT_MODEL, 4'd0, 32'h00010000);
      load_elem(vmp_pkg::MAT_MODEL, 4'd5, 32'h00010000);
      drain();

      idle_pct = 0;  stall_pct = 0;  random_run(450);
      drain();
      idle_pct = 45; stall_pct = 0;
      // long receiver hold-off while items keep coming
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (3000) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      random_run(450);
      drain();
      idle_pct = 0;  stall_pct = 45; random_run(450);
      drain();
      idle_pct = 22; stall_pct = 22; random_run(450);
      drain();

      repeat (600) @(posedge clock);
      $display("run covered %0d vertices (%0d with zero w) plus matrix loads",
               vertex_count, zero_w_count);
      $display("under four idle/stall mixes and a long receiver hold-off");
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
